### hw/rtl/bmhq_pkg.sv
// Shared types and constants of the max-priority queue.
// Depends on nothing; every other file of the block takes names from here.
`default_nettype none

package bmhq_pkg;

   localparam int VALUE_W       = 32;
   localparam int STATUS_W      = 2;
   localparam int FILL_W        = 11;
   localparam int DEFAULT_DEPTH = 1024;

   typedef enum logic [0:0] {
      FUNC_PUSH = 1'b0,
      FUNC_POP  = 1'b1
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   // Command broadcast to every cell for one accepted item.
   typedef struct packed {
      logic                      push;
      logic                      pop;
      logic signed [VALUE_W-1:0] value;
   } cmd_type;

endpackage

`default_nettype wire

### hw/rtl/bmhq_req_if.sv
// Request channel of the queue: valid/ready handshake with func and push value.
// Depends on bmhq_pkg for the field widths.
`default_nettype none

interface bmhq_req_if;
   logic                               valid;
   logic                               ready;
   logic [0:0]                         func;
   logic signed [bmhq_pkg::VALUE_W-1:0] push_value;

   modport source (output valid, output func, output push_value, input ready);
   modport sink   (input valid, input func, input push_value, output ready);
endinterface

`default_nettype wire

### hw/rtl/bmhq_rsp_if.sv
// Response channel of the queue: valid/ready handshake with popped value,
// status and fill level. Depends on bmhq_pkg for the field widths.
`default_nettype none

interface bmhq_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [bmhq_pkg::VALUE_W-1:0] popped_value;
   logic [bmhq_pkg::STATUS_W-1:0]       status;
   logic [bmhq_pkg::FILL_W-1:0]         fill_level;

   modport source (output valid, output popped_value, output status, output fill_level,
                   input ready);
   modport sink   (input valid, input popped_value, input status, input fill_level,
                   output ready);
endinterface

`default_nettype wire

### hw/rtl/bmhq_cell.sv
// One slot of the sorted cell chain: holds a value, inserts or shifts.
// Depends on bmhq_pkg.
`default_nettype none

module bmhq_cell #(
   parameter int DEPTH = bmhq_pkg::DEFAULT_DEPTH,
   parameter int INDEX = 0
) (
   input  wire logic                                clock,
   input  wire bmhq_pkg::cmd_type                   cmd,
   input  wire logic [$clog2(DEPTH+1)-1:0]          count,
   input  wire logic signed [bmhq_pkg::VALUE_W-1:0] left_value,
   input  wire logic                                left_greater,
   input  wire logic signed [bmhq_pkg::VALUE_W-1:0] right_value,
   output logic signed [bmhq_pkg::VALUE_W-1:0]      value,
   output logic                                     greater
);

   localparam int CNT_W = $clog2(DEPTH+1);

   logic signed [bmhq_pkg::VALUE_W-1:0] value_ff;
   logic signed [bmhq_pkg::VALUE_W-1:0] value_in;
   logic                                occupied;

   // An empty slot counts as smaller than anything.
   assign occupied = CNT_W'(INDEX) < count;
   assign greater  = !occupied || (cmd.value > value_ff);
   assign value    = value_ff;

   always_comb begin
      value_in = value_ff;
      if (cmd.push && greater) begin
         // first slot below the new value takes it, the rest shift down
         value_in = left_greater ? left_value : cmd.value;
      end else if (cmd.pop) begin
         value_in = right_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

`default_nettype wire

### hw/rtl/binary_max_heap_queue.sv
// Max-priority queue of signed 32-bit values, kept as a sorted chain of cells.
// The result of an item is in the output register in the cycle after accept.
// Throughput: one item per cycle unless the response stalls; cells shift in the same cycle.
// Reset (synchronous, active high) empties the queue and the output register;
// no clearing pass, cell contents beyond the fill count are never read.
// Depends on bmhq_pkg, bmhq_req_if, bmhq_rsp_if and bmhq_cell.
`default_nettype none

module binary_max_heap_queue #(
   parameter int DEPTH = bmhq_pkg::DEFAULT_DEPTH
) (
   input  wire logic   clock,
   input  wire logic   reset,
   bmhq_req_if.sink    req_chan,
   bmhq_rsp_if.source  rsp_chan
);

   localparam int CNT_W = $clog2(DEPTH+1);

   // Chain wiring: values sorted largest first in cells 0 .. count-1.
   logic signed [bmhq_pkg::VALUE_W-1:0] cell_value   [DEPTH];
   logic                                cell_greater [DEPTH];

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;

   logic                                rsp_valid_ff;
   logic                                rsp_valid_in;
   logic signed [bmhq_pkg::VALUE_W-1:0] rsp_popped_ff;
   logic signed [bmhq_pkg::VALUE_W-1:0] rsp_popped_in;
   bmhq_pkg::status_type                rsp_status_ff;
   bmhq_pkg::status_type                rsp_status_in;
   logic [bmhq_pkg::FILL_W-1:0]         rsp_fill_ff;
   logic [bmhq_pkg::FILL_W-1:0]         rsp_fill_in;

   logic              req_fire;
   logic              is_pop;
   logic              full;
   logic              empty;
   bmhq_pkg::cmd_type cmd;

   // Accept a new item whenever the output register is free or being drained.
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign is_pop         = req_chan.func == bmhq_pkg::FUNC_POP;
   assign full           = count_ff == CNT_W'(DEPTH);
   assign empty          = count_ff == '0;

   // Drop a push on full and a pop on empty before it reaches the cells.
   assign cmd.push  = req_fire && !is_pop && !full;
   assign cmd.pop   = req_fire && is_pop && !empty;
   assign cmd.value = req_chan.push_value;

   // Build the chain: each cell looks at its left and right neighbor only.
   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic signed [bmhq_pkg::VALUE_W-1:0] left_value;
      logic                                left_greater;
      logic signed [bmhq_pkg::VALUE_W-1:0] right_value;

      if (g == 0) begin : g_head
         assign left_value   = cmd.value;
         assign left_greater = 1'b0;
      end else begin : g_mid
         assign left_value   = cell_value[g-1];
         assign left_greater = cell_greater[g-1];
      end

      if (g == DEPTH-1) begin : g_tail
         assign right_value = cell_value[g];
      end else begin : g_body
         assign right_value = cell_value[g+1];
      end

      bmhq_cell #(
         .DEPTH (DEPTH),
         .INDEX (g)
      ) u_cell (
         .clock        (clock),
         .cmd          (cmd),
         .count        (count_ff),
         .left_value   (left_value),
         .left_greater (left_greater),
         .right_value  (right_value),
         .value        (cell_value[g]),
         .greater      (cell_greater[g])
      );
   end

   // Fill count and the response for the item being accepted.
   always_comb begin
      count_in      = count_ff;
      rsp_popped_in = rsp_popped_ff;
      rsp_status_in = rsp_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;

      if (cmd.push) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.pop) begin
         count_in = count_ff - CNT_W'(1);
      end

      if (req_fire) begin
         rsp_valid_in  = 1'b1;
         rsp_popped_in = cmd.pop ? cell_value[0] : '0;
         priority if (!is_pop && full) begin
            rsp_status_in = bmhq_pkg::STATUS_FULL;
         end else if (is_pop && empty) begin
            rsp_status_in = bmhq_pkg::STATUS_EMPTY;
         end else begin
            rsp_status_in = bmhq_pkg::STATUS_OK;
         end
      end
   end

   // The fill level reports the count masked to the field width.
   assign rsp_fill_in = req_fire ? bmhq_pkg::FILL_W'(count_in) : rsp_fill_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold the response payload until a new item replaces it.
   always_ff @(posedge clock) begin
      rsp_popped_ff <= rsp_popped_in;
      rsp_status_ff <= rsp_status_in;
      rsp_fill_ff   <= rsp_fill_in;
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.popped_value = rsp_popped_ff;
   assign rsp_chan.status       = rsp_status_ff;
   assign rsp_chan.fill_level   = rsp_fill_ff;

   // A successful pop shrinks the count by exactly one.
   a_pop_count: assert property (@(posedge clock) disable iff (reset)
      (req_fire && is_pop && !empty) |=> (count_ff == $past(count_ff) - CNT_W'(1)))
      else $error("pop did not decrement the fill count");

   // A push on a full queue leaves the count alone and reports full.
   a_push_full: assert property (@(posedge clock) disable iff (reset)
      (req_fire && !is_pop && full) |=>
         (count_ff == $past(count_ff) && rsp_status_ff == bmhq_pkg::STATUS_FULL))
      else $error("push on full queue was not dropped");

   // The two front cells stay in order: cell 1 never exceeds cell 0.
   a_front_order: assert property (@(posedge clock) disable iff (reset)
      (count_ff >= CNT_W'(2)) |-> !(cell_value[1] > cell_value[0]))
      else $error("front cells out of order");

   // The count never exceeds the capacity.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("fill count beyond capacity");

endmodule

`default_nettype wire
